>>> rtl/greedy_word_wrap_line_breaker_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the greedy word-wrap line breaker
// Immediate-consequence and next-cycle property forms with a common reset.
// ----------------------------------------------------------------------------
`ifndef GREEDY_WORD_WRAP_LINE_BREAKER_UNIT_MACROS_SVH
`define GREEDY_WORD_WRAP_LINE_BREAKER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GWWL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GWWL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gwwl_pkg.sv
// ----------------------------------------------------------------------------
// gwwl_pkg
// Shared types and constants of the greedy word-wrap line breaker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gwwl_pkg;

  // Input operations.
  localparam logic [1:0] OP_APPEND    = 2'd0;
  localparam logic [1:0] OP_NEXT_LINE = 2'd1;
  localparam logic [1:0] OP_CLEAR     = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WRAP_ENABLE = 2'd0;
  localparam logic [1:0] CFG_BOX_WIDTH   = 2'd1;
  localparam logic [1:0] CFG_ALIGN_MODE  = 2'd2;

  // Alignment modes.
  localparam logic [1:0] ALIGN_RIGHT  = 2'd1;
  localparam logic [1:0] ALIGN_CENTRE = 2'd2;

  // Field widths fixed by the interface.
  localparam int CP_W     = 21;
  localparam int GLYPH_W  = 12;
  localparam int START_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int LWIDTH_W = 22;
  localparam int OFFSET_W = 23;

  localparam int WIDTH_MAX = 4194303;

  // Code points with special handling.
  localparam logic [CP_W-1:0] CP_NEWLINE  = 21'h0000A;
  localparam logic [CP_W-1:0] CP_SPACE    = 21'h00020;
  localparam logic [CP_W-1:0] CP_DELETE   = 21'h0007F;
  localparam logic [CP_W-1:0] CP_C1_FIRST = 21'h00080;
  localparam logic [CP_W-1:0] CP_C1_LAST  = 21'h0009F;

  localparam int NUM_BLANKS = 17;
  localparam logic [CP_W-1:0] BLANK_TABLE [NUM_BLANKS] = '{
    21'h00020, 21'h01680, 21'h0180E, 21'h02000, 21'h02001, 21'h02002,
    21'h02003, 21'h02004, 21'h02005, 21'h02006, 21'h02007, 21'h02008,
    21'h02009, 21'h0200A, 21'h0200B, 21'h0205F, 21'h03000
  };

  // Classification of an incoming code point.
  typedef struct packed {
    logic drop;
    logic nl;
    logic ws;
  } glyph_class_t;

  // One stored glyph.
  typedef struct packed {
    logic                      nl;
    logic                      ws;
    logic [GLYPH_W-1:0]        adv;
    logic signed [GLYPH_W-1:0] bear;
    logic [GLYPH_W-1:0]        gw;
  } glyph_t;

endpackage

`default_nettype wire

>>> rtl/gwwl_classify.sv
// ----------------------------------------------------------------------------
// gwwl_classify
// Flags control characters, newlines and blank code points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gwwl_classify
  import gwwl_pkg::*;
(
  input  logic [CP_W-1:0] code_point_i,
  output glyph_class_t    class_o
);

  logic blank;

  always_comb begin
    blank = 1'b0;
    for (int i = 0; i < NUM_BLANKS; i++) begin
      if (code_point_i == BLANK_TABLE[i]) begin
        blank = 1'b1;
      end
    end
  end

  // C0 controls other than newline, delete and the C1 block are dropped.
  assign class_o.drop = (code_point_i < CP_NEWLINE) ||
                        ((code_point_i > CP_NEWLINE) && (code_point_i < CP_SPACE)) ||
                        (code_point_i == CP_DELETE) ||
                        ((code_point_i >= CP_C1_FIRST) && (code_point_i <= CP_C1_LAST));
  assign class_o.nl   = (code_point_i == CP_NEWLINE);
  assign class_o.ws   = blank;

endmodule

`default_nettype wire

>>> rtl/greedy_word_wrap_line_breaker_unit.sv
// ----------------------------------------------------------------------------
// greedy_word_wrap_line_breaker_unit
// Stores glyphs and hands out one laid-out line per next-line request.
//
// Input items arrive on in_valid_i / in_stall_o; an item is taken when valid
// is high and stall is low. An append or a clear gives no result. A next-line
// request reads the glyph store one entry per cycle through its single read
// port and walks the newline / blank / word state machine, then clamps the
// line width in a finish state before the result register; an exhausted text
// goes straight to the result. The block stalls its input from acceptance of
// a request until its result is registered. Results leave on out_valid_o /
// out_stall_i from an output register. While the receiver stalls, the result
// holds and appends or clears still proceed; a further request waits in its
// emit state until the register is free. Configuration writes are taken at
// any edge with cfg_we_i high; they apply to the next request only if made
// while idle, which the block does not enforce. Reset empties the store,
// rewinds the line start and clears all registers but rdata_q and the store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "greedy_word_wrap_line_breaker_unit_macros.svh"

module greedy_word_wrap_line_breaker_unit
  import gwwl_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_index_i,
  input  logic [15:0]                cfg_data_i,

  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 opcode_i,
  input  logic [CP_W-1:0]            code_point_i,
  input  logic [GLYPH_W-1:0]         advance_i,
  input  logic signed [GLYPH_W-1:0]  bearing_x_i,
  input  logic [GLYPH_W-1:0]         glyph_width_i,

  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       line_valid_o,
  output logic [START_W-1:0]         line_start_o,
  output logic [COUNT_W-1:0]         line_count_o,
  output logic [LWIDTH_W-1:0]        line_width_o,
  output logic signed [OFFSET_W-1:0] align_offset_o
);

  // Address and count widths follow the store depth. Running sums of advances
  // need twelve more bits than the count; the signed line width two more.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + GLYPH_W;
  localparam int WW = SW + 2;
  localparam int EW = (WW > 24) ? WW : 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    SC_HEAD,
    SC_LEAD_GAP,
    SC_GAP,
    SC_WORD,
    SC_FIRST_WORD
  } scan_e;

  // Configuration registers.
  logic                wrap_q, wrap_d;
  logic [15:0]         box_q, box_d;
  logic [1:0]          align_q, align_d;

  // Sequencer and scan datapath.
  state_e              state_q, state_d;
  scan_e               scan_q, scan_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       nls_q, nls_d;
  logic [CW-1:0]       begin_q, begin_d;
  logic [CW-1:0]       p_q, p_d;
  logic [CW-1:0]       end_q, end_d;
  logic [CW-1:0]       backup_q, backup_d;
  logic [CW-1:0]       nxt_q, nxt_d;
  logic [SW-1:0]       pre_q, pre_d;
  logic signed [WW-1:0] prev_w_q, prev_w_d;
  logic signed [WW-1:0] w_end_q, w_end_d;
  logic signed [WW-1:0] w_backup_q, w_backup_d;
  logic [LWIDTH_W-1:0] wclamp_q, wclamp_d;
  logic                res_valid_q, res_valid_d;

  // Output register.
  logic                       out_valid_q, out_valid_d;
  logic                       line_valid_q, line_valid_d;
  logic [START_W-1:0]         line_start_q, line_start_d;
  logic [COUNT_W-1:0]         line_count_q, line_count_d;
  logic [LWIDTH_W-1:0]        line_width_q, line_width_d;
  logic signed [OFFSET_W-1:0] align_offset_q, align_offset_d;

  // Glyph store.
  glyph_t              glyph_mem_q [CAPACITY];
  glyph_t              rdata_q;
  glyph_t              new_entry;
  logic                mem_we;
  logic [AW-1:0]       rd_addr;

  glyph_class_t        cls;
  logic                in_acc;
  logic [CW-1:0]       p_inc;
  logic [SW-1:0]       run;
  logic                over;
  logic signed [WW-1:0] w1;
  logic signed [EW-1:0] w_ext;
  logic signed [24:0]  diff;
  logic signed [24:0]  half_pos;
  logic signed [24:0]  half_neg;
  logic                stop;

  gwwl_classify u_classify (
    .code_point_i (code_point_i),
    .class_o      (cls)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign new_entry.nl   = cls.nl;
  assign new_entry.ws   = cls.ws;
  assign new_entry.adv  = advance_i;
  assign new_entry.bear = bearing_x_i;
  assign new_entry.gw   = glyph_width_i;

  // While scanning, the entry after the one under evaluation is fetched so
  // that one entry is consumed per cycle.
  assign p_inc   = p_q + CW'(1);
  assign rd_addr = (state_q == ST_IDLE) ? nls_q[AW-1:0] : p_inc[AW-1:0];

  // Running sum including the current glyph, and the width the line would
  // have if it ended on the current glyph.
  assign run  = pre_q + SW'(rdata_q.adv);
  assign over = wrap_q && (run > box_q);
  assign w1   = WW'($signed({1'b0, pre_q})) + WW'(rdata_q.bear) +
                WW'($signed({1'b0, rdata_q.gw}));

  assign w_ext = EW'(w_end_q);

  // Alignment arithmetic; centre rounds half away from zero.
  assign diff     = $signed({9'b0, box_q}) - $signed({3'b0, wclamp_q});
  assign half_pos = (diff + 25'sd1) >>> 1;
  assign half_neg = -((-diff + 25'sd1) >>> 1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      glyph_mem_q[count_q[AW-1:0]] <= new_entry;
    end
    rdata_q <= glyph_mem_q[rd_addr];
  end

  always_comb begin
    wrap_d         = wrap_q;
    box_d          = box_q;
    align_d        = align_q;
    state_d        = state_q;
    scan_d         = scan_q;
    count_d        = count_q;
    nls_d          = nls_q;
    begin_d        = begin_q;
    p_d            = p_q;
    end_d          = end_q;
    backup_d       = backup_q;
    nxt_d          = nxt_q;
    pre_d          = pre_q;
    prev_w_d       = prev_w_q;
    w_end_d        = w_end_q;
    w_backup_d     = w_backup_q;
    wclamp_d       = wclamp_q;
    res_valid_d    = res_valid_q;
    out_valid_d    = out_valid_q && out_stall_i;
    line_valid_d   = line_valid_q;
    line_start_d   = line_start_q;
    line_count_d   = line_count_q;
    line_width_d   = line_width_q;
    align_offset_d = align_offset_q;
    mem_we         = 1'b0;
    stop           = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WRAP_ENABLE: wrap_d  = cfg_data_i[0];
        CFG_BOX_WIDTH:   box_d   = cfg_data_i;
        CFG_ALIGN_MODE:  align_d = cfg_data_i[1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (opcode_i)
            OP_APPEND: begin
              if (!cls.drop && (count_q != CW'(CAPACITY))) begin
                mem_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
            end
            OP_NEXT_LINE: begin
              begin_d = nls_q;
              if (nls_q >= count_q) begin
                res_valid_d = 1'b0;
                state_d     = ST_EMIT;
              end else begin
                res_valid_d = 1'b1;
                p_d         = nls_q;
                end_d       = nls_q;
                backup_d    = nls_q;
                nxt_d       = nls_q;
                pre_d       = '0;
                w_end_d     = '0;
                w_backup_d  = '0;
                scan_d      = SC_HEAD;
                state_d     = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              nls_d   = '0;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        unique case (scan_q)
          SC_HEAD: begin
            if (rdata_q.nl) begin
              nxt_d = p_inc;
              stop  = 1'b1;
            end else if (rdata_q.ws) begin
              scan_d = SC_LEAD_GAP;
            end else begin
              end_d   = p_inc;
              w_end_d = w1;
              scan_d  = wrap_q ? SC_FIRST_WORD : SC_WORD;
            end
          end
          SC_LEAD_GAP: begin
            nxt_d = p_q;
            if (rdata_q.nl) begin
              nxt_d = p_inc;
              stop  = 1'b1;
            end else if (over) begin
              stop = 1'b1;
            end else if (!rdata_q.ws) begin
              end_d   = p_inc;
              w_end_d = w1;
              scan_d  = SC_WORD;
            end
          end
          SC_GAP: begin
            if (rdata_q.nl) begin
              nxt_d = p_inc;
              stop  = 1'b1;
            end else if (!rdata_q.ws) begin
              if (wrap_q) begin
                nxt_d = p_q;
              end
              if (over) begin
                stop = 1'b1;
              end else begin
                end_d   = p_inc;
                w_end_d = w1;
                scan_d  = SC_WORD;
              end
            end
          end
          SC_WORD: begin
            if (rdata_q.nl) begin
              nxt_d = p_inc;
              stop  = 1'b1;
            end else if (rdata_q.ws) begin
              end_d      = p_q;
              w_end_d    = prev_w_q;
              backup_d   = p_q;
              w_backup_d = prev_w_q;
              scan_d     = SC_GAP;
            end else if (over) begin
              // Word does not fit: fall back to the last word boundary.
              end_d   = backup_q;
              w_end_d = w_backup_q;
              stop    = 1'b1;
            end else begin
              end_d   = p_inc;
              w_end_d = w1;
            end
          end
          SC_FIRST_WORD: begin
            if (rdata_q.nl) begin
              end_d   = p_q;
              w_end_d = prev_w_q;
              nxt_d   = p_inc;
              stop    = 1'b1;
            end else if (rdata_q.ws) begin
              end_d      = p_q;
              w_end_d    = prev_w_q;
              backup_d   = p_q;
              w_backup_d = prev_w_q;
              scan_d     = SC_GAP;
            end else if (over) begin
              // The first word alone overflows: split it here.
              end_d   = p_q;
              w_end_d = prev_w_q;
              nxt_d   = p_q;
              stop    = 1'b1;
            end else begin
              end_d   = p_inc;
              w_end_d = w1;
            end
          end
          default: ;
        endcase

        if (stop) begin
          nls_d   = nxt_d;
          state_d = ST_FINISH;
        end else if (p_inc == count_q) begin
          nls_d   = count_q;
          state_d = ST_FINISH;
        end else begin
          p_d      = p_inc;
          pre_d    = run;
          prev_w_d = w1;
        end
      end

      ST_FINISH: begin
        if (w_ext < 0) begin
          wclamp_d = '0;
        end else if (w_ext > EW'(WIDTH_MAX)) begin
          wclamp_d = LWIDTH_W'(WIDTH_MAX);
        end else begin
          wclamp_d = LWIDTH_W'(w_end_q);
        end
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
          if (res_valid_q) begin
            line_valid_d = 1'b1;
            line_start_d = START_W'(begin_q);
            line_count_d = COUNT_W'(end_q - begin_q);
            line_width_d = wclamp_q;
            case (align_q)
              ALIGN_RIGHT:  align_offset_d = OFFSET_W'(diff);
              ALIGN_CENTRE: align_offset_d = (diff >= 0) ? OFFSET_W'(half_pos)
                                                         : OFFSET_W'(half_neg);
              default:      align_offset_d = '0;
            endcase
          end else begin
            line_valid_d   = 1'b0;
            line_start_d   = '0;
            line_count_d   = '0;
            line_width_d   = '0;
            align_offset_d = '0;
          end
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q         <= 1'b0;
      box_q          <= '0;
      align_q        <= '0;
      state_q        <= ST_IDLE;
      scan_q         <= SC_HEAD;
      count_q        <= '0;
      nls_q          <= '0;
      begin_q        <= '0;
      p_q            <= '0;
      end_q          <= '0;
      backup_q       <= '0;
      nxt_q          <= '0;
      pre_q          <= '0;
      prev_w_q       <= '0;
      w_end_q        <= '0;
      w_backup_q     <= '0;
      wclamp_q       <= '0;
      res_valid_q    <= 1'b0;
      out_valid_q    <= 1'b0;
      line_valid_q   <= 1'b0;
      line_start_q   <= '0;
      line_count_q   <= '0;
      line_width_q   <= '0;
      align_offset_q <= '0;
    end else begin
      wrap_q         <= wrap_d;
      box_q          <= box_d;
      align_q        <= align_d;
      state_q        <= state_d;
      scan_q         <= scan_d;
      count_q        <= count_d;
      nls_q          <= nls_d;
      begin_q        <= begin_d;
      p_q            <= p_d;
      end_q          <= end_d;
      backup_q       <= backup_d;
      nxt_q          <= nxt_d;
      pre_q          <= pre_d;
      prev_w_q       <= prev_w_d;
      w_end_q        <= w_end_d;
      w_backup_q     <= w_backup_d;
      wclamp_q       <= wclamp_d;
      res_valid_q    <= res_valid_d;
      out_valid_q    <= out_valid_d;
      line_valid_q   <= line_valid_d;
      line_start_q   <= line_start_d;
      line_count_q   <= line_count_d;
      line_width_q   <= line_width_d;
      align_offset_q <= align_offset_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_valid_o   = line_valid_q;
  assign line_start_o   = line_start_q;
  assign line_count_o   = line_count_q;
  assign line_width_o   = line_width_q;
  assign align_offset_o = align_offset_q;

  // The fill count never passes the store depth.
  `GWWL_ASSERT_SAME(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(CAPACITY), "store overfilled")
  // The saved line start never lies beyond the stored text.
  `GWWL_ASSERT_SAME(a_start_bound, clk_i, rst_ni, 1'b1, nls_q <= count_q, "line start beyond text")
  // The scan pointer stays inside the stored text.
  `GWWL_ASSERT_SAME(a_scan_range, clk_i, rst_ni, state_q == ST_SCAN, p_q < count_q, "scan past text")
  // A finished line lies between its start and the end of the text.
  `GWWL_ASSERT_SAME(a_line_range, clk_i, rst_ni, state_q == ST_FINISH, (end_q >= begin_q) && (end_q <= count_q), "line end out of range")
  // Finishing always leads straight to the result stage.
  `GWWL_ASSERT_NEXT(a_finish_emit, clk_i, rst_ni, state_q == ST_FINISH, state_q == ST_EMIT, "finish not followed by emit")

endmodule

`default_nettype wire
